FILE: rtl/fepc_pkg.sv
// Shared constants, codes and the job command type of the flash erase/program controller.
package fepc_pkg;

  localparam int unsigned FEPC_FLASH_BYTES = 2097152;

  localparam int OP_W     = 3;
  localparam int ADDR_W   = 22;
  localparam int LEN_W    = 22;
  localparam int IDX_W    = 21;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] ERASED_RESET = 8'hFF;

  localparam logic [OP_W-1:0] OP_ERASE   = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPARE = 3'd3;
  localparam logic [OP_W-1:0] OP_BLANK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BLANK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH  = 2'd3;

  typedef enum logic [2:0] {
    JOB_REJECT,
    JOB_ERASE,
    JOB_WRITE,
    JOB_READ,
    JOB_COMPARE,
    JOB_BLANK
  } job_kind_t;

  typedef struct packed {
    job_kind_t           kind;
    logic                first;
    logic                in_job;
    logic                done;
    logic [ADDR_W-1:0]   start;
    logic [LEN_W-1:0]    len;
    logic [ADDR_W:0]     addr;
    logic [BYTE_W-1:0]   data;
  } job_cmd_t;

endpackage

FILE: rtl/fepc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fepc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fepc_front.sv
// Front end: accepts input words, range-checks them and turns them into job commands.
module fepc_front import fepc_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FEPC_FLASH_BYTES
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [ADDR_W-1:0] start_address,
  input  logic [LEN_W-1:0]  job_length,
  input  logic [IDX_W-1:0]  byte_index,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              clearing,
  input  logic              q_full,
  output logic              push,
  output job_cmd_t          cmd
);

  logic [31:0]      end_addr;
  logic             in_range;
  logic [LEN_W-1:0] idx_ext;
  logic             last_item;

  assign in_ready = !clearing && !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    end_addr  = 32'(start_address) + 32'(job_length);
    // The end of the range bounds the start as well, since the length is never negative.
    in_range  = end_addr <= 32'(FLASH_BYTES);
    idx_ext   = LEN_W'(byte_index);
    last_item = (idx_ext + LEN_W'(1)) >= job_length;

    cmd.first  = byte_index == '0;
    cmd.in_job = idx_ext < job_length;
    cmd.start  = start_address;
    cmd.len    = job_length;
    cmd.addr   = (ADDR_W+1)'(start_address) + (ADDR_W+1)'(byte_index);
    cmd.data   = data_byte;
    cmd.done   = last_item;

    unique case (op)
      OP_ERASE: begin
        cmd.kind = JOB_ERASE;
        cmd.done = 1'b1;
      end
      OP_WRITE:   cmd.kind = JOB_WRITE;
      OP_READ:    cmd.kind = JOB_READ;
      OP_COMPARE: cmd.kind = JOB_COMPARE;
      OP_BLANK: begin
        cmd.kind = JOB_BLANK;
        cmd.done = 1'b1;
      end
      default: begin
        cmd.kind = JOB_REJECT;
        cmd.done = 1'b1;
      end
    endcase

    if (!in_range) begin
      cmd.kind = JOB_REJECT;
    end
  end

endmodule

FILE: rtl/fepc_queue.sv
// Short command queue between the front end and the sequencer.
module fepc_queue import fepc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  job_cmd_t din,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output job_cmd_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_cmd_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign dout      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= din;
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/fepc_back.sv
// Sequencer: clears the array after reset and carries out job commands on the flash store.
module fepc_back import fepc_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FEPC_FLASH_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [BYTE_W-1:0]              cfg_wdata,
  input  logic                           q_valid,
  input  job_cmd_t                       q_head,
  output logic                           q_pop,
  output logic                           clearing,
  output logic                           ram_we,
  output logic [$clog2(FLASH_BYTES)-1:0] ram_waddr,
  output logic [BYTE_W-1:0]              ram_wdata,
  output logic [$clog2(FLASH_BYTES)-1:0] ram_raddr,
  input  logic [BYTE_W-1:0]              ram_rdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [STATUS_W-1:0]            status,
  output logic [BYTE_W-1:0]              read_byte,
  output logic                           job_done
);

  localparam int AW = $clog2(FLASH_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ERASE,
    S_SCAN,
    S_READ,
    S_EMIT
  } state_t;

  state_t              state;
  logic [AW-1:0]       clr_addr;
  job_cmd_t            job;
  logic [LEN_W-1:0]    cnt;
  logic                scan_ok;
  logic                rd_pend;
  logic                write_allowed;
  logic                compare_failed;
  logic [BYTE_W-1:0]   erased_value;
  logic [STATUS_W-1:0] res_status;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_done;

  logic [AW-1:0]       walk_addr;
  logic [AW-1:0]       head_addr;
  logic [AW-1:0]       job_addr;
  logic                walk_end;
  logic                ok_now;
  logic                cf_hold;
  logic                cf_read;

  assign clearing = state == S_CLEAR;
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    walk_addr = AW'(32'(job.start) + 32'(cnt));
    head_addr = AW'(q_head.addr);
    job_addr  = AW'(job.addr);
    walk_end  = cnt == job.len;
    // The byte read in the previous cycle of a walk is checked here.
    ok_now    = scan_ok && !(rd_pend && (ram_rdata != erased_value));
    cf_hold   = q_head.first ? 1'b0 : compare_failed;
    cf_read   = (job.first ? 1'b0 : compare_failed) || (ram_rdata != job.data);

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = erased_value;
    ram_raddr = '0;

    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = ERASED_RESET;
      end
      S_IDLE: begin
        if (q_valid) begin
          ram_raddr = head_addr;
          if ((q_head.kind == JOB_WRITE) && !q_head.first && write_allowed &&
              q_head.in_job) begin
            ram_we    = 1'b1;
            ram_waddr = head_addr;
            ram_wdata = q_head.data;
          end
        end
      end
      S_ERASE: begin
        if (!walk_end) begin
          ram_we    = 1'b1;
          ram_waddr = walk_addr;
        end
      end
      S_SCAN: begin
        ram_raddr = walk_addr;
        if (walk_end && (job.kind == JOB_WRITE) && ok_now && job.in_job) begin
          ram_we    = 1'b1;
          ram_waddr = job_addr;
          ram_wdata = job.data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      rd_pend        <= 1'b0;
      write_allowed  <= 1'b0;
      compare_failed <= 1'b0;
      erased_value   <= ERASED_RESET;
    end else begin
      if (cfg_we) begin
        erased_value <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_pend <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(FLASH_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (q_valid) begin
            job        <= q_head;
            cnt        <= '0;
            scan_ok    <= 1'b1;
            res_status <= ST_OK;
            res_byte   <= '0;
            res_done   <= q_head.done;
            unique case (q_head.kind)
              JOB_REJECT: begin
                res_status <= ST_RANGE;
                state      <= S_EMIT;
              end
              JOB_ERASE: state <= S_ERASE;
              JOB_BLANK: state <= S_SCAN;
              JOB_WRITE: begin
                if (q_head.first) begin
                  state <= S_SCAN;
                end else begin
                  if (!write_allowed) begin
                    res_status <= ST_NOT_BLANK;
                  end
                  state <= S_EMIT;
                end
              end
              JOB_READ, JOB_COMPARE: begin
                if (q_head.in_job) begin
                  state <= S_READ;
                end else begin
                  if (q_head.kind == JOB_COMPARE) begin
                    compare_failed <= cf_hold;
                    if (cf_hold) begin
                      res_status <= ST_MISMATCH;
                    end
                  end
                  state <= S_EMIT;
                end
              end
              default: begin
                res_status <= ST_RANGE;
                state      <= S_EMIT;
              end
            endcase
          end
        end

        S_ERASE: begin
          if (walk_end) begin
            state <= S_EMIT;
          end else begin
            cnt <= cnt + LEN_W'(1);
          end
        end

        S_SCAN: begin
          scan_ok <= ok_now;
          if (walk_end) begin
            if (job.kind == JOB_WRITE) begin
              write_allowed <= ok_now;
            end
            if (!ok_now) begin
              res_status <= ST_NOT_BLANK;
            end
            state <= S_EMIT;
          end else begin
            cnt     <= cnt + LEN_W'(1);
            rd_pend <= 1'b1;
          end
        end

        S_READ: begin
          if (job.kind == JOB_READ) begin
            res_byte <= ram_rdata;
          end else begin
            compare_failed <= cf_read;
            if (cf_read) begin
              res_status <= ST_MISMATCH;
            end
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            read_byte <= res_byte;
            job_done  <= res_done;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/flash_erase_program_controller.sv
// Top level of the flash erase/program controller: front end, command queue, sequencer, store.
// After reset the sequencer writes ERASED_RESET (8'hFF) into every byte, one byte per cycle,
// and the block takes no word while it clears; configuration is live.
// Per word: a rejected job, a later write word or a read or compare word beyond its job goes
// straight to the result, read and compare inside the job read one byte first, and erase,
// blank check and the first word of a write walk job_length bytes, one byte per cycle,
// through the store's ports. A result left waiting at the output holds the sequencer, and
// the two-entry queue then fills.
module flash_erase_program_controller import fepc_pkg::*; #(
  parameter int unsigned FLASH_BYTES = FEPC_FLASH_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [BYTE_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [ADDR_W-1:0]   start_address,
  input  logic [LEN_W-1:0]    job_length,
  input  logic [IDX_W-1:0]    byte_index,
  input  logic [BYTE_W-1:0]   data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [BYTE_W-1:0]   read_byte,
  output logic                job_done
);

  localparam int AW = $clog2(FLASH_BYTES);

  logic          clearing;
  logic          q_full;
  logic          push;
  job_cmd_t      cmd;
  logic          q_pop;
  logic          q_valid;
  job_cmd_t      q_head;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  fepc_front #(
    .FLASH_BYTES(FLASH_BYTES)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .start_address (start_address),
    .job_length    (job_length),
    .byte_index    (byte_index),
    .data_byte     (data_byte),
    .clearing      (clearing),
    .q_full        (q_full),
    .push          (push),
    .cmd           (cmd)
  );

  fepc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_head)
  );

  fepc_back #(
    .FLASH_BYTES(FLASH_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .read_byte (read_byte),
    .job_done  (job_done)
  );

  fepc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(FLASH_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the flash erase/program controller, with its own byte-level model.
module testbench import fepc_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FLASH = FEPC_FLASH_BYTES;
  localparam int unsigned ADDR_MAX = (1 << ADDR_W) - 1;
  localparam int unsigned IDX_MAX = (1 << IDX_W) - 1;
  localparam longint unsigned CYCLE_LIMIT = 12000000;
  localparam int unsigned WORDS_PER_PHASE = 360;

  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } job_word_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic                job_done;
  } job_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [BYTE_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op = '0;
  logic [ADDR_W-1:0]   start_address = '0;
  logic [LEN_W-1:0]    job_length = '0;
  logic [IDX_W-1:0]    byte_index = '0;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic                job_done;

  // Model state.
  bit [BYTE_W-1:0] flash_image [FLASH];
  bit              may_program;
  bit              mismatch_seen;
  logic [BYTE_W-1:0] erased_cfg;

  job_word_t  words_to_send [$];
  job_reply_t replies_due [$];
  job_word_t  taken_word;
  job_reply_t want_reply;

  int unsigned     words_made;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     mismatch_count;
  longint unsigned cycle_count;
  logic            in_fired;

  flash_erase_program_controller uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .start_address (start_address),
    .job_length    (job_length),
    .byte_index    (byte_index),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_byte     (read_byte),
    .job_done      (job_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit span_is_blank(input longint unsigned st, input longint unsigned ln);
    longint unsigned a;
    for (a = st; a < st + ln; a++) begin
      if (flash_image[int'(a)] != erased_cfg) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic compute_job_result(input job_word_t w, output job_reply_t r);
    longint unsigned st, ln, ix, a;
    bit in_range, in_job;
    st = w.start;
    ln = w.len;
    ix = w.idx;
    in_range = (st <= FLASH) && (st + ln <= FLASH);
    in_job = ix < ln;
    r.status = ST_OK;
    r.read_byte = '0;
    r.job_done = (ix + 1 >= ln);
    if (w.op == OP_ERASE || w.op >= OP_BLANK) r.job_done = 1'b1;
    if (w.op > OP_BLANK || !in_range) begin
      r.status = ST_RANGE;
    end else begin
      case (w.op)
        OP_ERASE: begin
          for (a = st; a < st + ln; a++) flash_image[int'(a)] = erased_cfg;
        end
        OP_WRITE: begin
          // The first word of a write decides whether the whole job may program.
          if (ix == 0) may_program = span_is_blank(st, ln);
          if (!may_program) r.status = ST_NOT_BLANK;
          else if (in_job) flash_image[int'(st + ix)] = w.data;
        end
        OP_READ: begin
          if (in_job) r.read_byte = flash_image[int'(st + ix)];
        end
        OP_COMPARE: begin
          if (ix == 0) mismatch_seen = 1'b0;
          if (in_job && flash_image[int'(st + ix)] != w.data) mismatch_seen = 1'b1;
          if (mismatch_seen) r.status = ST_MISMATCH;
        end
        default: begin
          if (!span_is_blank(st, ln)) r.status = ST_NOT_BLANK;
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Input side: a new word goes out only once the previous one has been taken.
  always @(negedge clk) begin
    job_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (words_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = words_to_send.pop_front();
        in_valid <= 1'b1;
        op <= w.op;
        start_address <= w.start;
        job_length <= w.len;
        byte_index <= w.idx;
        data_byte <= w.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken_word.op = op;
        taken_word.start = start_address;
        taken_word.len = job_length;
        taken_word.idx = byte_index;
        taken_word.data = data_byte;
        compute_job_result(taken_word, want_reply);
        replies_due.push_back(want_reply);
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word status=%0d read_byte=%02h job_done=%0d",
                                    status, read_byte, job_done));
        end else begin
          want_reply = replies_due.pop_front();
          if (status !== want_reply.status || read_byte !== want_reply.read_byte ||
              job_done !== want_reply.job_done) begin
            report_mismatch($sformatf(
              "expected status=%0d read_byte=%02h job_done=%0d, got %0d %02h %0d",
              want_reply.status, want_reply.read_byte, want_reply.job_done,
              status, read_byte, job_done));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("flash_erase_program_controller regression: fail");
      $finish;
    end
  end

  task automatic add_word(input logic [OP_W-1:0] o, input int unsigned st, input int unsigned ln,
                          input int unsigned ix, input int unsigned db);
    job_word_t w;
    w.op = o;
    w.start = ADDR_W'(st);
    w.len = LEN_W'(ln);
    w.idx = IDX_W'(ix);
    w.data = BYTE_W'(db);
    words_to_send.push_back(w);
    words_made++;
  endtask

  task automatic add_directed();
    add_word(OP_BLANK, 0, 16, 0, 0);
    add_word(OP_WRITE, 0, 0, 0, 8'h33);       // zero-length write is allowed
    add_word(OP_WRITE, 0, 4, 0, 8'h00);
    add_word(OP_WRITE, 0, 4, 1, 8'h5A);
    add_word(OP_WRITE, 0, 4, 2, 8'hA5);
    add_word(OP_WRITE, 0, 4, 3, 8'hFF);
    add_word(OP_READ, 0, 4, 0, 0);
    add_word(OP_READ, 0, 4, 3, 0);
    add_word(OP_COMPARE, 0, 4, 0, 8'h00);
    add_word(OP_COMPARE, 0, 4, 1, 8'h00);     // mismatch sticks for the rest of the job
    add_word(OP_COMPARE, 0, 4, 2, 8'hA5);
    add_word(OP_WRITE, 0, 4, 0, 8'h11);       // range no longer blank, so refused
    add_word(OP_WRITE, 0, 4, 2, 8'h22);
    add_word(OP_BLANK, 0, 4, 0, 0);
    add_word(OP_ERASE, 0, 4, IDX_MAX, 8'hFF);
    add_word(OP_BLANK, 0, 4, 0, 0);
    add_word(OP_ERASE, FLASH, 0, 0, 0);
    add_word(OP_READ, FLASH - 1, 1, 0, 0);
    add_word(OP_ERASE, FLASH - 1, 2, 0, 0);
    add_word(OP_BLANK, ADDR_MAX, ADDR_MAX, IDX_MAX, 8'hFF);
    add_word(OP_RSVD_5, 0, 4, IDX_MAX, 8'hFF);
    add_word(OP_RSVD_6, 0, 0, 0, 0);
    add_word(OP_RSVD_7, FLASH, 0, 0, 8'h80);
    add_word(OP_READ, 0, FLASH, IDX_MAX, 0);
    add_word(OP_READ, 0, 4, IDX_MAX, 0);      // index beyond the job reads nothing
    add_word(OP_COMPARE, 0, FLASH, IDX_MAX, 8'h00);
  endtask

  // An erase / blank / write / read / compare sequence on a small range.
  task automatic add_sequence();
    bit [BYTE_W-1:0] pattern [64];
    int unsigned base, ln, k, first_idx, corrupt_at, db;
    ln = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    if ($urandom_range(0, 1)) base = $urandom_range(0, 511);
    else base = FLASH - ln - $urandom_range(0, 511);
    for (k = 0; k < ln; k++) pattern[k] = BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0)
      add_word(OP_ERASE, base, ln, $urandom_range(0, IDX_MAX), $urandom_range(0, 255));
    if ($urandom_range(0, 1)) add_word(OP_BLANK, base, ln, $urandom_range(0, ln), 0);
    first_idx = ($urandom_range(0, 7) == 0) ? 1 : 0;
    for (k = first_idx; k < ln; k++) add_word(OP_WRITE, base, ln, k, pattern[k]);
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < ln; k++) add_word(OP_READ, base, ln, k, $urandom_range(0, 255));
    end
    corrupt_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ln - 1) : ln;
    for (k = 0; k < ln; k++) begin
      db = pattern[k];
      if (k == corrupt_at) db = db ^ (1 << $urandom_range(0, 7));
      add_word(OP_COMPARE, base, ln, k, db);
    end
    if ($urandom_range(0, 2) == 0) add_word(OP_BLANK, base, ln, 0, 0);
  endtask

  // Loose words; a large length is either out of range or used only where no long walk is started.
  task automatic add_noise_word();
    logic [OP_W-1:0] o;
    int unsigned st, ln, ix, pick;
    o = OP_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 9);
    ix = $urandom_range(0, IDX_MAX);
    if (pick < 6) begin
      ln = $urandom_range(0, 32);
      st = $urandom_range(0, 1) ? $urandom_range(0, 600) : FLASH - $urandom_range(0, 40);
      if ($urandom_range(0, 3) != 0) ix = $urandom_range(0, ln + 2);
    end else if (pick < 8) begin
      st = $urandom_range(0, ADDR_MAX);
      ln = $urandom_range(FLASH + 1, ADDR_MAX);
    end else if (pick < 9) begin
      st = $urandom_range(FLASH + 1, ADDR_MAX);
      ln = $urandom_range(0, ADDR_MAX);
    end else begin
      st = 0;
      ln = FLASH;
      if (o == OP_ERASE || o == OP_BLANK) o = OP_READ;
      if (o == OP_WRITE && ix == 0) ix = 1;
    end
    add_word(o, st, ln, ix, $urandom_range(0, 255));
  endtask

  task automatic set_erased_value(input logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    erased_cfg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase, target, k;
    logic [BYTE_W-1:0] ev;
    for (k = 0; k < FLASH; k++) flash_image[k] = 8'hFF;
    may_program = 1'b0;
    mismatch_seen = 1'b0;
    erased_cfg = ERASED_RESET;
    words_made = 0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 14; recv_idle_pct = 88; ev = 8'hFF; end
        1: begin send_idle_pct = 88; recv_idle_pct = 14; ev = 8'h00; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; ev = $urandom_range(1, 254); end
      endcase
      set_erased_value(ev);
      if (phase == 0) add_directed();
      target = words_made + WORDS_PER_PHASE;
      while (words_made < target) begin
        if ($urandom_range(0, 9) < 8) add_sequence();
        else repeat ($urandom_range(1, 4)) add_noise_word();
      end
      // Checked on the rising edge, where no word can be taken while in_valid is low.
      do @(posedge clk);
      while (words_to_send.size() != 0 || in_valid || replies_due.size() != 0);
      repeat (4) @(posedge clk);
    end

    repeat (20) @(posedge clk);
    if (replies_due.size() != 0) report_mismatch("replies still outstanding at the end");
    if (mismatch_count == 0) begin
      $display("flash_erase_program_controller regression: pass");
    end else begin
      $display("flash_erase_program_controller regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fepc_pkg.sv
rtl/fepc_ram.sv
rtl/fepc_front.sv
rtl/fepc_queue.sv
rtl/fepc_back.sv
rtl/flash_erase_program_controller.sv
tb/testbench.sv
